// File: sv/crlf_pkg.sv
// ----------------------------------------------------------------------------
// crlf_pkg
// Shared types and constants of the crlf line receive buffer.
// ----------------------------------------------------------------------------
package crlf_pkg;

   localparam int LINE_MAX_DEF = 64;

   localparam logic [1:0] OP_RX    = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_NUL = 8'h00;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CHECK,
      ST_SINGLE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic rx_byte;
      logic read_start;
      logic latch_single;
      logic single_ok;
      logic idx_inc;
      logic load_char;
      logic load_term;
      logic load_single;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic term_now;
      logic rd_zero;
      logic pending;
   } status_type;

endpackage

// File: sv/crlf_ram.sv
// ----------------------------------------------------------------------------
// crlf_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module crlf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/crlf_ctrl.sv
// ----------------------------------------------------------------------------
// crlf_ctrl
// Sequencer for byte intake, line readout and single-result transactions.
// ----------------------------------------------------------------------------
module crlf_ctrl import crlf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_max_len,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               priority case (req_operation)
                  OP_READ: begin
                     if (req_max_len == 8'd0 || !status.pending) begin
                        state_in = ST_SINGLE;
                     end else begin
                        state_in = ST_FETCH;
                     end
                  end
                  OP_QUERY: state_in = ST_SINGLE;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_FETCH: state_in = ST_CHECK;
         ST_CHECK: begin
            if (status.out_free) begin
               if (status.term_now || status.rd_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_SINGLE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               priority case (req_operation)
                  OP_RX: cmd.rx_byte = 1'b1;
                  OP_READ: begin
                     if (req_max_len == 8'd0 || !status.pending) begin
                        cmd.latch_single = 1'b1;
                        cmd.single_ok    = 1'b0;
                     end else begin
                        cmd.read_start = 1'b1;
                     end
                  end
                  OP_QUERY: begin
                     cmd.latch_single = 1'b1;
                     cmd.single_ok    = status.pending;
                  end
                  default: cmd = '0;
               endcase
            end
         end
         ST_FETCH: cmd = '0;
         ST_CHECK: begin
            if (status.out_free) begin
               if (status.term_now || status.rd_zero) begin
                  cmd.load_term = 1'b1;
               end else begin
                  cmd.load_char = 1'b1;
                  cmd.idx_inc   = 1'b1;
               end
            end
         end
         ST_SINGLE: cmd.load_single = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

// File: sv/crlf_dp.sv
// ----------------------------------------------------------------------------
// crlf_dp
// Line buffers, lengths, pending flag, read index and result register.
// ----------------------------------------------------------------------------
module crlf_dp import crlf_pkg::*; #(
   parameter int LINE_MAX = LINE_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_rx_byte,
   input  logic [7:0] req_max_len,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_line_ok,
   output logic [7:0] rsp_char_out,
   output logic       rsp_last
);

   localparam int LEN_W = $clog2(LINE_MAX);
   localparam logic [LEN_W-1:0] LEN_TOP = LEN_W'(LINE_MAX - 1);

   // two banks swap roles when a line is handed over, so no copy is needed
   logic             asm_bank_ff, asm_bank_in;
   logic [LEN_W-1:0] asm_len_ff, asm_len_in;
   logic [LEN_W-1:0] rdy_len_ff, rdy_len_in;
   logic             pending_ff, pending_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [7:0]       limit_ff, limit_in;
   logic             single_ok_ff, single_ok_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_line_ok_ff, rsp_line_ok_in;
   logic [7:0]       rsp_char_ff, rsp_char_in;
   logic             rsp_last_ff, rsp_last_in;

   logic       is_term;
   logic       wr_ok;
   logic       wr_en0, wr_en1;
   logic [7:0] rd_data0, rd_data1, rd_data;

   assign is_term = (req_rx_byte == CH_LF) || (req_rx_byte == CH_CR);
   assign wr_ok   = cmd.rx_byte && !is_term && (asm_len_ff < LEN_TOP);
   assign wr_en0  = wr_ok && !asm_bank_ff;
   assign wr_en1  = wr_ok && asm_bank_ff;

   crlf_ram #(.WIDTH(8), .DEPTH(LINE_MAX)) u_bank0 (
      .clock   (clock),
      .wr_en   (wr_en0),
      .wr_addr (asm_len_ff),
      .wr_data (req_rx_byte),
      .rd_addr (idx_ff),
      .rd_data (rd_data0)
   );

   crlf_ram #(.WIDTH(8), .DEPTH(LINE_MAX)) u_bank1 (
      .clock   (clock),
      .wr_en   (wr_en1),
      .wr_addr (asm_len_ff),
      .wr_data (req_rx_byte),
      .rd_addr (idx_ff),
      .rd_data (rd_data1)
   );

   // the ready line lives in the bank not being assembled
   assign rd_data = asm_bank_ff ? rd_data0 : rd_data1;

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.term_now = (idx_ff >= rdy_len_ff) || (8'(idx_ff) >= limit_ff);
   assign status.rd_zero  = (rd_data == CH_NUL);
   assign status.pending  = pending_ff;

   always_comb begin
      asm_bank_in    = asm_bank_ff;
      asm_len_in     = asm_len_ff;
      rdy_len_in     = rdy_len_ff;
      pending_in     = pending_ff;
      idx_in         = idx_ff;
      limit_in       = limit_ff;
      single_ok_in   = single_ok_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_line_ok_in = rsp_line_ok_ff;
      rsp_char_in    = rsp_char_ff;
      rsp_last_in    = rsp_last_ff;

      if (cmd.rx_byte) begin
         if (is_term) begin
            if (asm_len_ff != '0 && !pending_ff) begin
               asm_bank_in = !asm_bank_ff;
               rdy_len_in  = asm_len_ff;
               pending_in  = 1'b1;
            end
            asm_len_in = '0;
         end else if (asm_len_ff < LEN_TOP) begin
            asm_len_in = asm_len_ff + LEN_W'(1);
         end else begin
            // overlong line is thrown away
            asm_len_in = '0;
         end
      end

      if (cmd.read_start) begin
         idx_in   = '0;
         limit_in = req_max_len - 8'd1;
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + LEN_W'(1);
      end
      if (cmd.latch_single) begin
         single_ok_in = cmd.single_ok;
      end

      if (cmd.load_char) begin
         rsp_valid_in   = 1'b1;
         rsp_line_ok_in = 1'b1;
         rsp_char_in    = rd_data;
         rsp_last_in    = 1'b0;
      end
      if (cmd.load_term) begin
         rsp_valid_in   = 1'b1;
         rsp_line_ok_in = 1'b1;
         rsp_char_in    = CH_NUL;
         rsp_last_in    = 1'b1;
         pending_in     = 1'b0;
      end
      if (cmd.load_single) begin
         rsp_valid_in   = 1'b1;
         rsp_line_ok_in = single_ok_ff;
         rsp_char_in    = CH_NUL;
         rsp_last_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         asm_bank_ff  <= 1'b0;
         asm_len_ff   <= '0;
         rdy_len_ff   <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         asm_bank_ff  <= asm_bank_in;
         asm_len_ff   <= asm_len_in;
         rdy_len_ff   <= rdy_len_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      limit_ff       <= limit_in;
      single_ok_ff   <= single_ok_in;
      rsp_line_ok_ff <= rsp_line_ok_in;
      rsp_char_ff    <= rsp_char_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_line_ok  = rsp_line_ok_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// File: sv/crlf_line_receive_buffer.sv
// ----------------------------------------------------------------------------
// crlf_line_receive_buffer
// Collects received bytes into CR/LF terminated lines and hands them out.
// ----------------------------------------------------------------------------
// A received byte and an unused operation code give no result. A query, or
// a read that fails, gives one result. A successful read of n characters
// gives n+1 results: the transaction is taken first, then for each character
// and for the closing terminator come a fetch from the line RAM, whose read
// port is registered, and a check for a zero byte and the length limits
// before it goes to the result register. No new transaction is taken while
// a read or a query is under way; a finished result waiting in the result
// register does not hold back the next transaction. Two line RAMs swap
// roles when a line is handed over, so a finished line is never copied.
module crlf_line_receive_buffer import crlf_pkg::*; #(
   parameter int LINE_MAX = LINE_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_rx_byte,
   input  logic [7:0] req_max_len,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_line_ok,
   output logic [7:0] rsp_char_out,
   output logic       rsp_last
);

   cmd_type    cmd;
   status_type status;

   crlf_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_max_len   (req_max_len),
      .status        (status),
      .cmd           (cmd)
   );

   crlf_dp #(.LINE_MAX(LINE_MAX)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_rx_byte  (req_rx_byte),
      .req_max_len  (req_max_len),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_line_ok  (rsp_line_ok),
      .rsp_char_out (rsp_char_out),
      .rsp_last     (rsp_last)
   );

endmodule

// File: sv/crlf_checker.sv
// ----------------------------------------------------------------------------
// crlf_checker
// Port level checks on the result channel of the line receive buffer.
// ----------------------------------------------------------------------------
module crlf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_line_ok,
   input logic [7:0] rsp_char_out,
   input logic       rsp_last
);

   // stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_out)
         && $stable(rsp_last) && $stable(rsp_line_ok))
      else $error("result changed while stalled");

   // a failed read or clear flag is a lone closing result
   a_fail_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_line_ok |-> rsp_last && rsp_char_out == 8'h00)
      else $error("failed result not a single closing item");

   // line characters are never zero
   a_char_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_char_out != 8'h00 && rsp_line_ok)
      else $error("zero or failed line character");

   // closing terminator carries no character
   a_term_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_char_out == 8'h00)
      else $error("closing result carries a character");

endmodule

bind crlf_line_receive_buffer crlf_checker u_crlf_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_line_ok  (rsp_line_ok),
   .rsp_char_out (rsp_char_out),
   .rsp_last     (rsp_last)
);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the crlf line receive buffer. A directed table and
// a random stream of received bytes, reads and queries are driven with
// valid/ready on both sides. Every result is compared against an expected
// result from the table or from a line assembly predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_top import crlf_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int         LONG_HOLD = 300;

   typedef struct packed {
      logic       line_ok;
      logic [7:0] char_out;
      logic       last;
   } line_result_type;

   typedef struct packed {
      logic [1:0]      op;
      logic [7:0]      rx;
      logic [7:0]      ml;
      logic            typed;
      line_result_type want;
   } stim_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_operation;
   logic [7:0] req_rx_byte;
   logic [7:0] req_max_len;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_line_ok;
   logic [7:0] rsp_char_out;
   logic       rsp_last;

   // predictor state
   logic [7:0]   asm_text [LINE_MAX_DEF];
   logic [6:0]   asm_len;
   logic [7:0]   held_text [LINE_MAX_DEF];
   logic [6:0]   held_len;
   logic         held_pending;

   line_result_type expected_chars[$];
   line_result_type fresh_chars[$];
   stim_row_type    directed_rows [25];

   int  mismatch_count;
   int  accepted_count;
   bit  calm;
   bit  hold_request;
   int  hold_left;

   crlf_line_receive_buffer i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_operation(req_operation),
      .req_rx_byte  (req_rx_byte),
      .req_max_len  (req_max_len),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_line_ok  (rsp_line_ok),
      .rsp_char_out (rsp_char_out),
      .rsp_last     (rsp_last)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // line assembly and hand-out, results go to fresh_chars
   task automatic model_line_step(input logic [1:0] op, input logic [7:0] b,
                                  input logic [7:0] ml);
      int n;
      int cap;
      fresh_chars.delete();
      case (op)
         OP_RX: begin
            if (b == CH_LF || b == CH_CR) begin
               if (asm_len != 0 && !held_pending) begin
                  held_text    = asm_text;
                  held_len     = asm_len;
                  held_pending = 1'b1;
               end
               asm_len = '0;
            end else if (asm_len < LINE_MAX_DEF - 1) begin
               asm_text[asm_len] = b;
               asm_len = asm_len + 7'd1;
            end else begin
               // full line: drop it and the byte
               asm_len = '0;
            end
         end
         OP_READ: begin
            if (ml == 0 || !held_pending) begin
               fresh_chars.push_back('{1'b0, CH_NUL, 1'b1});
            end else begin
               n = 0;
               while (n < held_len && held_text[n] != CH_NUL) n++;
               cap = ml - 1;
               if (n > cap) n = cap;
               for (int k = 0; k < n; k++)
                  fresh_chars.push_back('{1'b1, held_text[k], 1'b0});
               fresh_chars.push_back('{1'b1, CH_NUL, 1'b1});
               held_pending = 1'b0;
            end
         end
         OP_QUERY: fresh_chars.push_back('{held_pending, CH_NUL, 1'b1});
         default: ;
      endcase
   endtask

   task automatic drive_req(input logic [1:0] op, input logic [7:0] b, input logic [7:0] ml,
                            input logic typed = 1'b0, input line_result_type want = '0);
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < 19) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_rx_byte   <= b;
      req_max_len   <= ml;
      do @(posedge clock); while (!req_ready);
      model_line_step(op, b, ml);
      if (typed) expected_chars.push_back(want);
      else foreach (fresh_chars[i]) expected_chars.push_back(fresh_chars[i]);
      if (op != OP_UNUSED) accepted_count++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (expected_chars.size() == 0);
   endtask

   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      if ($urandom_range(0, 9) == 0) return CH_NUL;
      do b = 8'($urandom_range(0, 255)); while (b == CH_LF || b == CH_CR);
      return b;
   endfunction

   function automatic logic [7:0] pick_max_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) return 8'd0;
      if (r < 35) return 8'($urandom_range(1, 4));
      if (r < 55) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   // line body plus a random terminator
   task automatic send_line(input int len);
      for (int i = 0; i < len; i++) drive_req(OP_RX, text_byte(), 8'($urandom_range(0, 255)));
      drive_req(OP_RX, $urandom_range(0, 1) ? CH_CR : CH_LF, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_read();
      drive_req(OP_READ, 8'($urandom_range(0, 255)), pick_max_len());
   endtask

   // result side: random stalls, plus one long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request) begin
         rsp_ready    <= 1'b0;
         hold_left    <= LONG_HOLD;
         hold_request <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= 19);
      end
   end

   always @(posedge clock) begin
      line_result_type want;
      line_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_line_ok, rsp_char_out, rsp_last};
         if (expected_chars.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected result ok=%0b char=%02h last=%0b",
                        $realtime, got.line_ok, got.char_out, got.last);
         end else begin
            want = expected_chars.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: exp ok/char/last %0b/%02h/%0b, got %0b/%02h/%0b",
                           $realtime, want.line_ok, want.char_out, want.last,
                           got.line_ok, got.char_out, got.last);
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("FAIL crlf_line_receive_buffer");
      $finish;
   end

   initial begin
      int start_count;
      int pick;
      int len;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_operation  = OP_RX;
      req_rx_byte    = '0;
      req_max_len    = '0;
      rsp_ready      = 1'b0;
      calm           = 1'b0;
      hold_request   = 1'b0;
      hold_left      = 0;
      mismatch_count = 0;
      accepted_count = 0;
      asm_len        = '0;
      held_len       = '0;
      held_pending   = 1'b0;

      directed_rows = '{
         '{OP_QUERY,  8'h00, 8'h00, 1'b1, '{1'b0, CH_NUL, 1'b1}},  // nothing after reset
         '{OP_READ,   8'h00, 8'hFF, 1'b1, '{1'b0, CH_NUL, 1'b1}},  // read with nothing pending
         '{OP_RX,     CH_LF, 8'h00, 1'b0, '0},                     // terminators on empty line
         '{OP_RX,     CH_CR, 8'hFF, 1'b0, '0},
         '{OP_RX,     8'h41, 8'h00, 1'b0, '0},
         '{OP_RX,     8'hFF, 8'h00, 1'b0, '0},
         '{OP_RX,     CH_NUL, 8'h00, 1'b0, '0},                    // zero byte inside the line
         '{OP_RX,     8'h42, 8'h00, 1'b0, '0},
         '{OP_RX,     CH_CR, 8'h00, 1'b0, '0},
         '{OP_QUERY,  8'hFF, 8'hFF, 1'b1, '{1'b1, CH_NUL, 1'b1}},
         '{OP_READ,   8'h00, 8'h00, 1'b1, '{1'b0, CH_NUL, 1'b1}},  // zero max_len fails
         '{OP_RX,     8'h78, 8'h00, 1'b0, '0},
         '{OP_RX,     8'h79, 8'h00, 1'b0, '0},
         '{OP_RX,     CH_LF, 8'h00, 1'b0, '0},                     // lost, line still pending
         '{OP_UNUSED, 8'hFF, 8'hFF, 1'b0, '0},
         '{OP_READ,   8'h00, 8'hFF, 1'b0, '0},
         '{OP_READ,   8'h00, 8'h05, 1'b1, '{1'b0, CH_NUL, 1'b1}},
         '{OP_RX,     8'h01, 8'h00, 1'b0, '0},
         '{OP_RX,     8'h80, 8'h00, 1'b0, '0},
         '{OP_RX,     CH_LF, 8'h00, 1'b0, '0},
         '{OP_READ,   8'h00, 8'h02, 1'b0, '0},                     // truncated to one char
         '{OP_QUERY,  8'h00, 8'h00, 1'b1, '{1'b0, CH_NUL, 1'b1}},
         '{OP_RX,     8'h7A, 8'h00, 1'b0, '0},
         '{OP_RX,     CH_CR, 8'h00, 1'b0, '0},
         '{OP_READ,   8'h00, 8'h01, 1'b0, '0}                      // terminator only
      };

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         drive_req(directed_rows[i].op, directed_rows[i].rx, directed_rows[i].ml,
                   directed_rows[i].typed, directed_rows[i].want);
      wait_drained();

      // line read out while the result side holds off
      hold_request = 1'b1;
      send_line(4);
      drive_req(OP_READ, 8'h00, 8'hFF);
      send_line(2);
      drive_req(OP_QUERY, 8'h00, 8'h00);
      send_read();
      wait_drained();

      // overlong line gets discarded, sent with no idling on either side
      calm = 1'b1;
      send_line(LINE_MAX_DEF + $urandom_range(0, 2));
      drive_req(OP_READ, 8'h00, 8'hFF);
      calm = 1'b0;
      wait_drained();

      start_count = accepted_count;
      while (accepted_count - start_count < 12) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            len = $urandom_range(0, 7);
            send_line(len);
            if ($urandom_range(0, 9) < 7) send_read();
         end else if (pick < 70) begin
            send_read();
         end else if (pick < 80) begin
            drive_req(OP_QUERY, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end else begin
            drive_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
         end
      end
      wait_drained();
      repeat (16) @(posedge clock);

      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("PASS crlf_line_receive_buffer");
      end else begin
         $display("FAIL crlf_line_receive_buffer");
      end
      $finish;
   end

endmodule
